// ----- design/dmc_pkg.sv -----
package dmc_pkg;

    localparam int MAX_LINES_DEF  = 1024;
    localparam int ADDR_WIDTH_DEF = 32;

    localparam int TAG_W      = 32;
    localparam int LINE_OUT_W = 10;
    localparam int COUNT_W    = 32;
    localparam int TIME_W     = 48;
    localparam int COST_W     = 16;
    localparam int FIELD_W    = 4;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_HIT_COST    = 2'd2;
    localparam logic [1:0] REG_MISS_COST   = 2'd3;

    localparam logic [FIELD_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [FIELD_W-1:0] INDEX_BITS_RST  = 4'd10;
    localparam logic [COST_W-1:0]  HIT_COST_RST    = 16'd1;
    localparam logic [COST_W-1:0]  MISS_COST_RST   = 16'd100;

endpackage

// ----- design/dmc_intf.sv -----
interface dmc_access_if #(
    parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

interface dmc_result_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [dmc_pkg::LINE_OUT_W-1:0] line_index;
    logic [dmc_pkg::TAG_W-1:0]      tag_value;
    logic [dmc_pkg::COUNT_W-1:0]    hit_count;
    logic [dmc_pkg::COUNT_W-1:0]    access_count;
    logic [dmc_pkg::TIME_W-1:0]     elapsed_time;

    modport source (
        output valid, output hit, output line_index, output tag_value,
        output hit_count, output access_count, output elapsed_time,
        input ready
    );
    modport sink (
        input valid, input hit, input line_index, input tag_value,
        input hit_count, input access_count, input elapsed_time,
        output ready
    );
endinterface

// ----- design/direct_mapped_cache_tag_check_unit.sv -----
// Channel   Dir  Payload                                          Handshake
// acc       in   access_address                                   valid/ready
// res       out  hit, line_index, tag_value, hit_count,           valid/ready
//                access_count, elapsed_time
// apb       in   offset_bits, index_bits, hit_cost, miss_cost     psel/penable, pready=1
//
// One transaction per cycle: read of the tag memory in the first stage, compare
// and write-back in the second, then the output register. A same-line access
// right behind another is forwarded from the second stage.
// After reset the valid bits are cleared, one line a cycle, with acc.ready low
// until every line is cleared. res stalls hold the second stage and then acc.
module direct_mapped_cache_tag_check_unit #(
    parameter int MAX_LINES  = dmc_pkg::MAX_LINES_DEF,
    parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    dmc_access_if.sink                       acc,
    dmc_result_if.source                     res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dmc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dmc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dmc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int LIM   = $clog2(MAX_LINES + 1) - 1;
    localparam int TAG_W = dmc_pkg::TAG_W;
    localparam int CNT_W = dmc_pkg::COUNT_W;
    localparam int TM_W  = dmc_pkg::TIME_W;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } entry_t;

    entry_t tag_mem [MAX_LINES];

    // configuration
    logic [dmc_pkg::FIELD_W-1:0] offset_bits_reg;
    logic [dmc_pkg::FIELD_W-1:0] index_bits_reg;
    logic [dmc_pkg::COST_W-1:0]  hit_cost_reg;
    logic [dmc_pkg::COST_W-1:0]  miss_cost_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= dmc_pkg::OFFSET_BITS_RST;
            index_bits_reg  <= dmc_pkg::INDEX_BITS_RST;
            hit_cost_reg    <= dmc_pkg::HIT_COST_RST;
            miss_cost_reg   <= dmc_pkg::MISS_COST_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                dmc_pkg::REG_OFFSET_BITS: offset_bits_reg <= pwdata[3:0];
                dmc_pkg::REG_INDEX_BITS:  index_bits_reg  <= pwdata[3:0];
                dmc_pkg::REG_HIT_COST:    hit_cost_reg    <= pwdata[15:0];
                dmc_pkg::REG_MISS_COST:   miss_cost_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dmc_pkg::REG_OFFSET_BITS: prdata = {28'd0, offset_bits_reg};
            dmc_pkg::REG_INDEX_BITS:  prdata = {28'd0, index_bits_reg};
            dmc_pkg::REG_HIT_COST:    prdata = {16'd0, hit_cost_reg};
            dmc_pkg::REG_MISS_COST:   prdata = {16'd0, miss_cost_reg};
            default:                  prdata = '0;
        endcase
    end

    // valid clear after reset
    logic             clearing_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == IDX_W'(MAX_LINES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // pipeline control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_adv;
    logic acc_fire;

    assign out_free  = !out_valid_reg || res.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign acc.ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign acc_fire  = acc.valid && acc.ready;

    // address split
    logic [4:0]       ib_eff;
    logic [63:0]      rest;
    logic [IDX_W-1:0] line_mask;
    logic [IDX_W-1:0] line_c;
    logic [TAG_W-1:0] tag_c;

    always_comb
    begin
        ib_eff    = ({1'b0, index_bits_reg} > 5'(LIM)) ? 5'(LIM) : {1'b0, index_bits_reg};
        rest      = 64'(acc.access_address[ADDR_WIDTH-1:0]) >> offset_bits_reg;
        line_mask = ~({IDX_W{1'b1}} << ib_eff);
        line_c    = rest[IDX_W-1:0] & line_mask;
        tag_c     = TAG_W'(rest >> ib_eff);
    end

    // stage 1
    logic [IDX_W-1:0] s1_line_reg;
    logic [TAG_W-1:0] s1_tag_reg;
    entry_t           rd_data_reg;
    logic             fwd_reg;
    logic [TAG_W-1:0] fwd_tag_reg;
    entry_t           cur;
    logic             hit_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (acc_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire)
        begin
            s1_line_reg <= line_c;
            s1_tag_reg  <= tag_c;
            rd_data_reg <= tag_mem[line_c];
            fwd_reg     <= s1_adv && (s1_line_reg == line_c);
            fwd_tag_reg <= s1_tag_reg;
        end
    end

    // an entry leaving stage 1 always holds its own tag, valid
    always_comb
    begin
        cur   = fwd_reg ? entry_t'{valid: 1'b1, tag: fwd_tag_reg} : rd_data_reg;
        hit_c = cur.valid && (cur.tag == s1_tag_reg);
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            tag_mem[clr_addr_reg] <= '0;
        end
        else if (s1_adv && !hit_c)
        begin
            tag_mem[s1_line_reg] <= entry_t'{valid: 1'b1, tag: s1_tag_reg};
        end
    end

    // counters
    logic [CNT_W-1:0] hits_reg;
    logic [CNT_W-1:0] accesses_reg;
    logic [TM_W-1:0]  time_reg;
    logic [CNT_W-1:0] hits_next;
    logic [CNT_W-1:0] accesses_next;
    logic [TM_W-1:0]  time_next;
    logic [TM_W:0]    time_sum;

    always_comb
    begin
        accesses_next = (accesses_reg == '1) ? accesses_reg : accesses_reg + 1'b1;
        hits_next     = (hit_c && hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
        time_sum      = (TM_W + 1)'(time_reg)
                      + (TM_W + 1)'(hit_c ? hit_cost_reg : miss_cost_reg);
        time_next     = time_sum[TM_W] ? '1 : time_sum[TM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            accesses_reg  <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                hits_reg      <= hits_next;
                accesses_reg  <= accesses_next;
                time_reg      <= time_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    logic                           out_hit_reg;
    logic [dmc_pkg::LINE_OUT_W-1:0] out_line_reg;
    logic [TAG_W-1:0]               out_tag_reg;
    logic [31:0]                    line_ext;

    assign line_ext = 32'(s1_line_reg);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_hit_reg  <= hit_c;
            out_line_reg <= line_ext[dmc_pkg::LINE_OUT_W-1:0];
            out_tag_reg  <= s1_tag_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.hit          = out_hit_reg;
    assign res.line_index   = out_line_reg;
    assign res.tag_value    = out_tag_reg;
    assign res.hit_count    = hits_reg;
    assign res.access_count = accesses_reg;
    assign res.elapsed_time = time_reg;

endmodule
